>>> hw/rtl/swci_pkg.sv
// Package for the swath column incidence angle block.
// Holds geometry constants, codes and the query record shared by all modules.
// No dependencies.
package swci_pkg;

  // Table depth and platform geometry, distances in meters.
  localparam int unsigned MAX_SWATHS      = 8;
  localparam longint unsigned PLATFORM_HEIGHT = 64'd693000;
  localparam longint unsigned EARTH_RADIUS    = 64'd6371000;

  // Derived geometry constants.
  localparam longint unsigned GeoK =
      64'd2 * PLATFORM_HEIGHT * EARTH_RADIUS + PLATFORM_HEIGHT * PLATFORM_HEIGHT;
  localparam logic [71:0] GeoKShift = 72'(GeoK) << 20;
  localparam logic [25:0] GeoSum = 26'(PLATFORM_HEIGHT + EARTH_RADIUS);

  // Pi in Q30 for the final angle scaling.
  localparam logic [31:0] PiQ30 = 32'hC90FDAA2;

  // Iteration counts of the serial units.
  localparam int unsigned DivSteps  = 30;
  localparam int unsigned AcosSteps = 22;

  // Item function codes.
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  // Register index of image_width on the configuration port.
  localparam logic RegImageWidth = 1'b0;

  // Classified query handed from the front to the back.
  typedef struct packed {
    logic        ok;
    logic [15:0] diff;
    logic [31:0] near;
    logic [25:0] spacing;
  } query_t;

endpackage

>>> hw/rtl/swci_in_if.sv
// Input channel of the swath column incidence angle block.
// Carries valid, ready and the item fields. No dependencies.
interface swci_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [2:0]  entry_index;
  logic [15:0] start_col;
  logic [15:0] swath_width;
  logic [31:0] near_range;
  logic [25:0] range_spacing;
  logic [15:0] column;

  modport source(output valid, func, entry_index, start_col, swath_width, near_range,
                 range_spacing, column, input ready);
  modport sink(input valid, func, entry_index, start_col, swath_width, near_range,
               range_spacing, column, output ready);
endinterface

>>> hw/rtl/swci_out_if.sv
// Result channel of the swath column incidence angle block.
// Carries valid, ready and the result fields. No dependencies.
interface swci_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [35:0] slant_range;
  logic [16:0] incidence;

  modport source(output valid, found, slant_range, incidence, input ready);
  modport sink(input valid, found, slant_range, incidence, output ready);
endinterface

>>> hw/rtl/swath_column_incidence_angle.sv
// Swath column incidence angle block: swath table, range and angle per column.
// Write items are taken once the queue has room. A query with geometry gets its result from
// the 30-step divider and 22-step arc-cosine in the back part; a query whose cosine clamps
// skips both, and a rejected query goes straight to the result stage.
// Queries are worked one at a time, a new one taken only in idle; a two-entry queue decouples
// the front. Asynchronous active-low reset clears the table widths, image width and queues.
module swath_column_incidence_angle #(
  parameter int unsigned MaxSwaths = swci_pkg::MAX_SWATHS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swci_in_if.sink     in_i,
  swci_out_if.source  out_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import swci_pkg::*;

  logic [15:0] image_width_q;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  query_t      push_data, pop_data;

  // Configuration register port.
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == RegImageWidth) ? {16'd0, image_width_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= '0;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 (paddr_i[2] == RegImageWidth)) begin
      image_width_q <= pwdata_i[15:0];
    end
  end

  swci_front #(.MaxSwaths(MaxSwaths)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .image_width_i(image_width_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  swci_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  swci_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_o      (out_o)
  );

  // A result without geometry carries zero range and angle.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.found) |-> (out_o.slant_range == '0 && out_o.incidence == '0))
    else $error("not-found result has nonzero fields");

  // A found result always has a positive slant range.
  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.found) |-> (out_o.slant_range != '0))
    else $error("found result with zero slant range");

  // The angle never exceeds a quarter turn.
  a_angle_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.incidence <= 17'd102944))
    else $error("incidence angle out of range");

endmodule

>>> hw/rtl/swci_front.sv
// Front part: accepts items, keeps the swath table and classifies queries.
// Depends on swci_pkg and swci_in_if.
module swci_front #(
  parameter int unsigned MaxSwaths = swci_pkg::MAX_SWATHS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  swci_in_if.sink            in_i,
  input  logic [15:0]        image_width_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output swci_pkg::query_t   push_data_o
);
  import swci_pkg::*;

  logic [15:0] start_q [MaxSwaths];
  logic [15:0] width_q [MaxSwaths];
  logic [31:0] near_q  [MaxSwaths];
  logic [25:0] sp_q    [MaxSwaths];

  logic                 accept;
  logic                 is_write;
  logic [MaxSwaths-1:0] hit;
  logic [15:0]          sel_start;
  logic [31:0]          sel_near;
  logic [25:0]          sel_sp;

  // Every item waits for room in the queue, so order is kept.
  assign in_i.ready   = push_ready_i;
  assign accept       = in_i.valid && in_i.ready;
  assign is_write     = (in_i.func == FuncWrite);
  assign push_valid_o = in_i.valid && (in_i.func == FuncQuery);

  // Span part of the table is cleared by reset; width zero disables an entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxSwaths; i++) begin
        start_q[i] <= '0;
        width_q[i] <= '0;
      end
    end else if (accept && is_write) begin
      for (int i = 0; i < MaxSwaths; i++) begin
        if ({29'd0, in_i.entry_index} == 32'(i)) begin
          start_q[i] <= in_i.start_col;
          width_q[i] <= in_i.swath_width;
        end
      end
    end
  end

  // Ranging part is only read for an entry that a write has enabled.
  always_ff @(posedge clk_i) begin
    if (accept && is_write) begin
      for (int i = 0; i < MaxSwaths; i++) begin
        if ({29'd0, in_i.entry_index} == 32'(i)) begin
          near_q[i] <= in_i.near_range;
          sp_q[i]   <= in_i.range_spacing;
        end
      end
    end
  end

  // Coverage test of every entry in parallel.
  always_comb begin
    for (int i = 0; i < MaxSwaths; i++) begin
      hit[i] = ({1'b0, in_i.column} >= {1'b0, start_q[i]}) &&
               ({1'b0, in_i.column} < ({1'b0, start_q[i]} + {1'b0, width_q[i]}));
    end
  end

  // The lowest-numbered covering entry wins.
  always_comb begin
    sel_start = '0;
    sel_near  = '0;
    sel_sp    = '0;
    for (int i = MaxSwaths - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel_start = start_q[i];
        sel_near  = near_q[i];
        sel_sp    = sp_q[i];
      end
    end
  end

  // Classification of the query.
  always_comb begin
    push_data_o.ok      = (in_i.column < image_width_i) && (|hit) &&
                          (sel_near != '0) && (sel_sp != '0);
    push_data_o.diff    = in_i.column - sel_start;
    push_data_o.near    = sel_near;
    push_data_o.spacing = sel_sp;
  end

endmodule

>>> hw/rtl/swci_queue.sv
// Two-entry queue of classified queries between the front and the back.
// Depends on swci_pkg.
module swci_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  swci_pkg::query_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output swci_pkg::query_t pop_data_o
);
  import swci_pkg::*;

  query_t     slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage of the queued items.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/swci_back.sv
// Back part: slant range, cosine by serial division, arc-cosine by doubling.
// Depends on swci_pkg and swci_out_if.
module swci_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  swci_pkg::query_t pop_data_i,
  swci_out_if.source       out_o
);
  import swci_pkg::*;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StRMul = 4'd1;
  localparam logic [3:0] StRAdd = 4'd2;
  localparam logic [3:0] StSq   = 4'd3;
  localparam logic [3:0] StSum  = 4'd4;
  localparam logic [3:0] StCmp  = 4'd5;
  localparam logic [3:0] StDiv  = 4'd6;
  localparam logic [3:0] StAcos = 4'd7;
  localparam logic [3:0] StFin  = 4'd8;

  logic [3:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;

  logic        found_q;
  logic [15:0] diff_q;
  logic [31:0] near_q;
  logic [25:0] sp_q;
  logic [41:0] prod_q;
  logic [33:0] r_q;
  logic [63:0] sq_q;
  logic [33:0] cross_q;
  logic [57:0] dlo_q;
  logic [27:0] dhi_q;
  logic [71:0] num_q;
  logic [71:0] den_q;
  logic [71:0] rem_q;
  logic [28:0] quo_q;
  logic [31:0] c_q;
  logic        par_q;
  logic [21:0] frac_q;
  logic        res_found_q;
  logic [35:0] res_range_q;
  logic [16:0] res_inc_q;

  logic        slot_free;
  logic [72:0] rem_sh;
  logic        div_ge;
  logic        c_neg;
  logic [30:0] c_mag;
  logic [32:0] c_sqr;
  logic [53:0] ang_prod;

  assign slot_free   = !out_valid_q || out_o.ready;
  assign pop_ready_o = (state_q == StIdle);

  // One restoring division step.
  always_comb begin
    rem_sh = {rem_q, 1'b0};
    div_ge = (rem_sh >= {1'b0, den_q});
  end

  // One angle doubling step: doubled square of the magnitude in Q30, rounded.
  always_comb begin
    c_neg = c_q[31];
    c_mag = c_neg ? 31'(-c_q) : 31'(c_q);
    c_sqr = 33'((64'(c_mag) * 64'(c_mag) + 64'd268435456) >> 29);
  end

  // Scaling of the angle fraction by pi, rounded.
  assign ang_prod = 54'(frac_q) * 54'(PiQ30) + 54'h8_0000_0000;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          state_d = pop_data_i.ok ? StRMul : StFin;
        end
      end
      StRMul: state_d = StRAdd;
      StRAdd: state_d = StSq;
      StSq:   state_d = StSum;
      StSum:  state_d = StCmp;
      StCmp: begin
        cnt_d   = '0;
        state_d = (num_q >= den_q) ? StFin : StDiv;
      end
      StDiv: begin
        if (cnt_q == 5'(DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = StAcos;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      StAcos: begin
        if (cnt_q == 5'(AcosSteps - 1)) begin
          state_d = StFin;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      StFin: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers, loaded by the step in progress.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        found_q <= pop_data_i.ok;
        diff_q  <= pop_data_i.diff;
        near_q  <= pop_data_i.near;
        sp_q    <= pop_data_i.spacing;
        frac_q  <= '0;
      end
      StRMul: prod_q <= 42'(diff_q) * 42'(sp_q);
      StRAdd: r_q <= {2'b00, near_q} + 34'((43'(prod_q) + 43'd512) >> 10);
      StSq: begin
        sq_q    <= 64'(r_q[31:0]) * 64'(r_q[31:0]);
        cross_q <= 34'(r_q[33:32]) * 34'(r_q[31:0]);
        dlo_q   <= 58'(r_q[31:0]) * 58'(GeoSum);
        dhi_q   <= 28'(r_q[33:32]) * 28'(GeoSum);
      end
      StSum: begin
        num_q <= 72'(sq_q) + (72'(cross_q) << 33) +
                 (72'(4'(r_q[33:32]) * 4'(r_q[33:32])) << 64) + GeoKShift;
        den_q <= (72'(dlo_q) + (72'(dhi_q) << 32)) << 11;
      end
      StCmp: begin
        rem_q  <= num_q;
        quo_q  <= '0;
        frac_q <= '0;
      end
      StDiv: begin
        rem_q <= 72'(div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh);
        quo_q <= {quo_q[27:0], div_ge};
        if (cnt_q == 5'(DivSteps - 1)) begin
          c_q   <= {2'b00, quo_q, div_ge};
          par_q <= 1'b0;
        end
      end
      StAcos: begin
        par_q  <= par_q ^ c_neg;
        frac_q <= {frac_q[20:0], par_q ^ c_neg};
        c_q    <= 32'(34'(c_sqr) - 34'h0_4000_0000);
      end
      StFin: begin
        if (slot_free) begin
          res_found_q <= found_q;
          res_range_q <= found_q ? 36'(r_q) : '0;
          res_inc_q   <= found_q ? 17'(ang_prod >> 36) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = res_found_q;
  assign out_o.slant_range = res_range_q;
  assign out_o.incidence   = res_inc_q;

endmodule

>>> bench/swath_column_incidence_angle_tb.sv
// Testbench for the swath column incidence angle block.
// Drives swath table writes and column queries, predicts range and angle, checks results.
// Depends on swci_pkg, swci_in_if, swci_out_if and the block itself.
module swath_column_incidence_angle_tb;
  import swci_pkg::*;

  typedef struct packed {
    logic        found;
    logic [35:0] slant_range;
    logic [16:0] incidence;
  } geo_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel_i = 1'b0;
  logic        penable_i = 1'b0;
  logic        pwrite_i = 1'b0;
  logic [2:0]  paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  swci_in_if  in_ch();
  swci_out_if out_ch();

  swath_column_incidence_angle dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch),
    .psel_i(psel_i), .penable_i(penable_i), .pwrite_i(pwrite_i), .paddr_i(paddr_i),
    .pwdata_i(pwdata_i), .prdata_o(prdata_o), .pready_o(pready_o)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: image width and swath table.
  localparam int MaxSwathsTb = MAX_SWATHS;
  logic [15:0] img_width;
  logic [15:0] tbl_start [MaxSwathsTb];
  logic [15:0] tbl_width [MaxSwathsTb];
  logic [31:0] tbl_near  [MaxSwathsTb];
  logic [25:0] tbl_step  [MaxSwathsTb];

  geo_t geo_pending[$];
  int   mismatches = 0;
  bit   quiet_send = 1'b0;
  bit   quiet_recv = 1'b0;

  // Arc-cosine by angle doubling; cosine in Q30, angle in units 2^-16 rad.
  function automatic logic [16:0] acos_q30(longint c);
    logic [63:0] frac;
    logic        par;
    logic [63:0] m;
    logic [63:0] t;
    logic [95:0] prod;
    frac = 0;
    par = 1'b0;
    for (int k = 0; k < AcosSteps; k++) begin
      par ^= (c < 0);
      frac = (frac << 1) | 64'(par);
      m = (c < 0) ? 64'(-c) : 64'(c);
      t = (m * m + (64'd1 << 28)) >> 29;
      c = longint'(t) - longint'(64'd1 << 30);
    end
    prod = 96'(frac) * 96'(PiQ30) + (96'd1 << 35);
    return 17'(prod >> 36);
  endfunction

  // Incidence angle for slant range r (units 2^-10 m).
  function automatic logic [16:0] incidence_for(logic [35:0] r);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] rem;
    longint       q;
    num = 128'(r) * 128'(r) + (128'(GeoK) << 20);
    den = 128'(r) * (128'(PLATFORM_HEIGHT + EARTH_RADIUS) << 11);
    if (num >= den) return '0;
    rem = num;
    q = 0;
    for (int i = 0; i < DivSteps; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    return acos_q30(q);
  endfunction

  // Query lookup: first covering swath, then range and angle.
  function automatic geo_t locate_column(logic [15:0] col);
    geo_t g;
    int   hit;
    logic [47:0] off;
    g = '0;
    hit = -1;
    if (col >= img_width) return g;
    for (int i = 0; i < MaxSwathsTb; i++) begin
      if (hit < 0 && tbl_width[i] != 0 && 17'(col) >= 17'(tbl_start[i]) &&
          17'(col) < 17'(tbl_start[i]) + 17'(tbl_width[i]))
        hit = i;
    end
    if (hit < 0) return g;
    if (tbl_near[hit] == 0 || tbl_step[hit] == 0) return g;
    off = (48'(col - tbl_start[hit]) * 48'(tbl_step[hit]) + 48'd512) >> 10;
    g.found = 1'b1;
    g.slant_range = 36'(tbl_near[hit]) + 36'(off);
    g.incidence = incidence_for(g.slant_range);
    return g;
  endfunction

  // Send one item and update the prediction at acceptance.
  // Valid stays high between items sent back to back and drops only in idle cycles.
  task automatic send_item(logic fn, logic [2:0] idx, logic [15:0] st, logic [15:0] wd,
                           logic [31:0] nr, logic [25:0] sp, logic [15:0] col);
    while (!quiet_send && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.entry_index <= idx;
    in_ch.start_col <= st;
    in_ch.swath_width <= wd;
    in_ch.near_range <= nr;
    in_ch.range_spacing <= sp;
    in_ch.column <= col;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (fn == FuncWrite) begin
      if (32'(idx) < MaxSwathsTb) begin
        tbl_start[idx] = st;
        tbl_width[idx] = wd;
        tbl_near[idx] = nr;
        tbl_step[idx] = sp;
      end
    end else begin
      geo_pending.push_back(locate_column(col));
    end
  endtask

  task automatic write_swath(int idx, int st, int wd, logic [31:0] nr, logic [25:0] sp);
    send_item(FuncWrite, 3'(idx), 16'(st), 16'(wd), nr, sp, 16'($urandom));
  endtask

  task automatic query_column(int col);
    send_item(FuncQuery, 3'($urandom), 16'($urandom), 16'($urandom), $urandom,
              26'($urandom), 16'(col));
  endtask

  // Stop sending, wait for all results, then let the block settle before a register write.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (geo_pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_image_width(logic [15:0] w);
    drain();
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= 1'b1;
    paddr_i <= 3'({RegImageWidth, 2'b00});
    pwdata_i <= 32'(w);
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    img_width = w;
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    geo_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (geo_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: found=%0d range=%0d angle=%0d",
                                       out_ch.found, out_ch.slant_range, out_ch.incidence);
      end else begin
        want = geo_pending.pop_front();
        if (want.found !== out_ch.found || want.slant_range !== out_ch.slant_range ||
            want.incidence !== out_ch.incidence) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected found=%0d range=%0d angle=%0d, got %0d %0d %0d",
                     want.found, want.slant_range, want.incidence,
                     out_ch.found, out_ch.slant_range, out_ch.incidence);
        end
      end
    end
  end

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    out_ch.ready <= quiet_recv ? 1'b1 : ($urandom_range(99) >= 23);
  end

  task automatic test_rejects();
    set_image_width(16'd0);
    query_column(0);
    query_column(65535);
    set_image_width(16'hFFFF);
    query_column(65535);
    query_column(100);
    write_swath(0, 0, 10, 32'd0, 26'd1000);
    write_swath(1, 0, 20, 32'd5000000, 26'd0);
    query_column(5);
    query_column(15);
  endtask

  task automatic test_extremes();
    write_swath(0, 0, 0, 32'd1, 26'd1);
    write_swath(1, 0, 100, 32'hFFFFFFFF, 26'h3FFFFFF);
    write_swath(2, 50, 200, 32'd1, 26'd1);
    write_swath(3, 65534, 65535, 32'd700000000, 26'h3FFFFFF);
    query_column(0);
    query_column(99);
    query_column(120);
    query_column(65534);
    write_swath(1, 0, 0, 32'd0, 26'd0);
    query_column(60);
    query_column(0);
    write_swath(4, 0, 65535, 32'd730000000, 26'd2500000);
    query_column(65534);
  endtask

  task automatic test_random_queries();
    int cols;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: set_image_width(16'($urandom_range(1, 65535)));
        1: set_image_width(16'hFFFF);
        default: set_image_width(16'd1000);
      endcase
      quiet_send = (ph == 1);
      quiet_recv = (ph == 1);
      for (int i = 0; i < MaxSwathsTb; i++)
        write_swath(i, $urandom_range(0, 900), $urandom_range(0, 300),
                    ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(0, 32'hFFFFFFFF)),
                    ($urandom_range(9) == 0) ? 26'd0 : 26'($urandom));
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(9) == 0)
          send_item(FuncWrite, 3'($urandom), 16'($urandom_range(0, 900)),
                    16'($urandom_range(0, 300)),
                    ($urandom_range(1) == 0) ? 32'($urandom_range(600000000, 900000000))
                                              : 32'($urandom),
                    26'($urandom), 16'($urandom));
        else begin
          cols = ($urandom_range(7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1300);
          query_column(cols);
        end
      end
      quiet_send = 1'b0;
      quiet_recv = 1'b0;
    end
  endtask

  // Stimulus sequence.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.entry_index = '0;
    in_ch.start_col = '0;
    in_ch.swath_width = '0;
    in_ch.near_range = '0;
    in_ch.range_spacing = '0;
    in_ch.column = '0;
    out_ch.ready = 1'b0;
    img_width = '0;
    for (int i = 0; i < MaxSwathsTb; i++) begin
      tbl_start[i] = '0;
      tbl_width[i] = '0;
      tbl_near[i] = '0;
      tbl_step[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_rejects();
    test_extremes();
    test_random_queries();
    drain();
    if (mismatches == 0 && geo_pending.size() == 0) begin
      $display("swath_column_incidence_angle_tb: PASS");
    end else begin
      $display("swath_column_incidence_angle_tb: FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #8000000;
    $display("swath_column_incidence_angle_tb: FAIL");
    $finish;
  end
endmodule
